/* rtl/pise_pkg.sv */
package pise_pkg;

    localparam int DEF_MAX_SHARES    = 16;
    localparam int DEF_MAX_THRESHOLD = 16;

    localparam logic [7:0] PRIME = 8'd251;
    localparam logic [7:0] CLIP  = 8'd250;

    // 256 reduced modulo the prime, used to fold the high byte down.
    localparam logic [2:0] FOLD = 3'd5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_SHARE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SHARE_COUNT_RESET = 5'd4;
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET   = 5'd2;

    localparam int INDEX_W = 5;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } coef_t;

    typedef struct packed {
        logic start;
        logic last_group;
    } eval_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eval_sts_t;

    // Reduces any 16-bit value modulo 251 with two folds and one subtract.
    function automatic logic [7:0] mod_prime(input logic [15:0] v);
        logic [10:0] t1;
        logic [8:0]  t2;
        logic [8:0]  t3;
        t1 = 11'(v[15:8]) * 11'(FOLD) + 11'(v[7:0]);
        t2 = 9'(t1[10:8]) * 9'(FOLD) + 9'(t1[7:0]);
        t3 = (t2 >= 9'(PRIME)) ? t2 - 9'(PRIME) : t2;
        return t3[7:0];
    endfunction

endpackage

/* rtl/polynomial_image_share_encoder_core.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  tdata: red, green, blue; tlast: end_of_image
// m_        out        m_tvalid/m_tready  tdata: share_index, share_red/green/blue;
//                                         tlast: last_of_run
// cfg_      in         cfg_valid/cfg_ready index 0 share_count, index 1 threshold
//
// One pixel is taken at a time: it is accepted in T_IDLE, then each coefficient is
// appended in T_APPEND and the next step is decided in T_NEXT. A completed group is
// evaluated for each share by the Horner loop that reads one coefficient per cycle
// from the coefficient RAM. Reset is synchronous and active low; the RAM
// needs no clearing. A stalled m_ side holds the evaluation at the output register.
module polynomial_image_share_encoder_core
    import pise_pkg::*;
#(
    parameter int MAX_SHARES    = DEF_MAX_SHARES,
    parameter int MAX_THRESHOLD = DEF_MAX_THRESHOLD
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // red, green, blue
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // share_index, red, green, blue, zero pad
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW = $clog2(MAX_SHARES + 1);
    localparam int FW = $clog2(MAX_THRESHOLD + 1);
    localparam int AW = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1;

    typedef enum logic [1:0] {T_IDLE, T_APPEND, T_EVAL, T_NEXT} t_state_t;

    t_state_t      state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    coef_t         coef0_reg, coef0_next;
    coef_t         coef1_reg, coef1_next;
    logic          two_reg, two_next;
    logic          eoi_reg, eoi_next;
    logic          sel_reg, sel_next;
    logic [CFG_DATA_W-1:0] share_count_reg;
    logic [CFG_DATA_W-1:0] threshold_reg;

    logic [XW-1:0] eff_shares;
    logic [FW-1:0] eff_thr;
    logic [FW-1:0] fill_inc;
    logic [FW-1:0] eval_count;
    logic          pend2;
    eval_cmd_t     cmd;
    eval_sts_t     sts;
    coef_t         pix, clipped, excess;
    logic          split;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    coef_t         ram_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    coef_t         rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            share_count_reg <= SHARE_COUNT_RESET;
            threshold_reg   <= THRESHOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SHARE_COUNT: share_count_reg <= cfg_data;
                REG_THRESHOLD:   threshold_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        if (share_count_reg == '0) begin
            eff_shares = XW'(1);
        end else if (32'(share_count_reg) > MAX_SHARES) begin
            eff_shares = XW'(MAX_SHARES);
        end else begin
            eff_shares = XW'(share_count_reg);
        end
        if (threshold_reg == '0) begin
            eff_thr = FW'(1);
        end else if (32'(threshold_reg) > MAX_THRESHOLD) begin
            eff_thr = FW'(MAX_THRESHOLD);
        end else begin
            eff_thr = FW'(threshold_reg);
        end
    end

    assign pix.red   = s_tdata[7:0];
    assign pix.green = s_tdata[15:8];
    assign pix.blue  = s_tdata[23:16];

    always_comb begin
        clipped.red   = (pix.red   >= CLIP) ? CLIP : pix.red;
        clipped.green = (pix.green >= CLIP) ? CLIP : pix.green;
        clipped.blue  = (pix.blue  >= CLIP) ? CLIP : pix.blue;
        excess.red    = (pix.red   >= CLIP) ? pix.red   - CLIP : '0;
        excess.green  = (pix.green >= CLIP) ? pix.green - CLIP : '0;
        excess.blue   = (pix.blue  >= CLIP) ? pix.blue  - CLIP : '0;
        split = (pix.red >= CLIP) || (pix.green >= CLIP) || (pix.blue >= CLIP);
    end

    assign fill_inc  = fill_reg + FW'(1);
    assign pend2     = two_reg && !sel_reg;
    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_wdata = sel_reg ? coef1_reg : coef0_reg;
    assign s_tready  = (state_reg == T_IDLE);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        coef0_next = coef0_reg;
        coef1_next = coef1_reg;
        two_next   = two_reg;
        eoi_next   = eoi_reg;
        sel_next   = sel_reg;
        ram_we     = 1'b0;
        cmd        = '0;
        eval_count = fill_inc;

        unique case (state_reg)
            T_IDLE: begin
                if (s_tvalid) begin
                    coef0_next = clipped;
                    coef1_next = excess;
                    two_next   = split;
                    eoi_next   = s_tlast;
                    sel_next   = 1'b0;
                    state_next = T_APPEND;
                end
            end
            T_APPEND: begin
                ram_we = 1'b1;
                if (fill_inc >= eff_thr) begin
                    // More results follow this group only if the second coefficient
                    // is still to come and will itself produce a group.
                    cmd.start      = 1'b1;
                    cmd.last_group = !(pend2 && (eoi_reg || eff_thr == FW'(1)));
                    fill_next      = '0;
                    state_next     = T_EVAL;
                end else begin
                    fill_next  = fill_inc;
                    state_next = T_NEXT;
                end
            end
            T_EVAL: begin
                if (sts.done) begin
                    state_next = T_NEXT;
                end
            end
            T_NEXT: begin
                if (pend2) begin
                    sel_next   = 1'b1;
                    state_next = T_APPEND;
                end else if (eoi_reg && fill_reg != '0) begin
                    cmd.start      = 1'b1;
                    cmd.last_group = 1'b1;
                    eval_count     = fill_reg;
                    fill_next      = '0;
                    eoi_next       = 1'b0;
                    state_next     = T_EVAL;
                end else begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        coef0_reg <= coef0_next;
        coef1_reg <= coef1_next;
        two_reg   <= two_next;
        eoi_reg   <= eoi_next;
        sel_reg   <= sel_next;
    end

    pise_ram #(
        .WIDTH ($bits(coef_t)),
        .DEPTH (MAX_THRESHOLD)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pise_eval #(
        .MAX_SHARES    (MAX_SHARES),
        .MAX_THRESHOLD (MAX_THRESHOLD)
    ) u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .count    (eval_count),
        .shares   (eff_shares),
        .sts      (sts),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.busy |-> state_reg == T_EVAL)
        else $error("Evaluation running outside the evaluation state.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !sts.busy)
        else $error("Coefficient write while the group is being read.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == T_IDLE |-> 32'(fill_reg) < MAX_THRESHOLD)
        else $error("Coefficient group left full between transactions.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:5] < PRIME) && (m_tdata[20:13] < PRIME)
                     && (m_tdata[28:21] < PRIME))
        else $error("Share value not reduced modulo the prime.");

endmodule

/* rtl/pise_ram.sv */
module pise_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/pise_eval.sv */
module pise_eval
    import pise_pkg::*;
#(
    parameter int MAX_SHARES    = DEF_MAX_SHARES,
    parameter int MAX_THRESHOLD = DEF_MAX_THRESHOLD,
    localparam int XW = $clog2(MAX_SHARES + 1),
    localparam int FW = $clog2(MAX_THRESHOLD + 1),
    localparam int AW = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  eval_cmd_t           cmd,
    input  logic [FW-1:0]       count,
    input  logic [XW-1:0]       shares,
    output eval_sts_t           sts,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  coef_t               rd_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    typedef enum logic [1:0] {E_IDLE, E_READ, E_DRAIN, E_OUT} e_state_t;

    e_state_t      state_reg, state_next;
    logic [XW-1:0] x_reg, x_next;
    logic [AW-1:0] j_reg, j_next;
    logic [FW-1:0] count_reg, count_next;
    coef_t         acc_reg, acc_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          last_group_reg, last_group_next;
    logic          out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    coef_t         out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;
    logic          load;

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        last_group_next = last_group_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        rd_valid_next   = (state_reg == E_READ);
        rd_en           = 1'b0;
        rd_addr         = j_reg;
        load            = 1'b0;
        sts.busy        = (state_reg != E_IDLE);
        sts.done        = 1'b0;

        // Horner step: acc = acc * x + c for each channel.
        if (rd_valid_reg) begin
            acc_next.red   = mod_prime(16'(acc_reg.red) * 16'(x_reg) + 16'(rd_data.red));
            acc_next.green = mod_prime(16'(acc_reg.green) * 16'(x_reg) + 16'(rd_data.green));
            acc_next.blue  = mod_prime(16'(acc_reg.blue) * 16'(x_reg) + 16'(rd_data.blue));
        end

        unique case (state_reg)
            E_IDLE: begin
                if (cmd.start) begin
                    count_next      = count;
                    j_next          = AW'(count - FW'(1));
                    x_next          = XW'(1);
                    acc_next        = '0;
                    last_group_next = cmd.last_group;
                    state_next      = E_READ;
                end
            end
            E_READ: begin
                rd_en = 1'b1;
                if (j_reg == '0) begin
                    state_next = E_DRAIN;
                end else begin
                    j_next = j_reg - AW'(1);
                end
            end
            E_DRAIN: begin
                state_next = E_OUT;
            end
            E_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    load           = 1'b1;
                    out_index_next = INDEX_W'(x_reg);
                    out_value_next = acc_reg;
                    out_last_next  = last_group_reg && (x_reg == shares);
                    if (x_reg == shares) begin
                        sts.done   = 1'b1;
                        state_next = E_IDLE;
                    end else begin
                        x_next     = x_reg + XW'(1);
                        j_next     = AW'(count_reg - FW'(1));
                        acc_next   = '0;
                        state_next = E_READ;
                    end
                end
            end
            default: state_next = E_IDLE;
        endcase

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= E_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
        x_reg          <= x_next;
        j_reg          <= j_next;
        count_reg      <= count_next;
        acc_reg        <= acc_next;
        last_group_reg <= last_group_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_value_reg.blue, out_value_reg.green,
                                 out_value_reg.red, out_index_reg});

endmodule
